[sv/sha256_stream_hasher_macros.svh]
// ----------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// short forms for the clocked checks in the checker
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// implication check, disabled in reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication check, disabled in reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

[sv/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha256 package
// types, round constants and round functions shared by the hasher
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		logic [0:0] operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// queue entry from front to back: one buffer write, maybe a compress and emit
	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_addr;
		logic [7:0] wr_data;
		logic       compress;
		logic       emit;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} core_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
			32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
		return h[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

[sv/sha_stream_if.sv]
// ----------------------------------------------------------------------------
// sha256 stream interface
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface sha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256 stream hasher
// byte-wide sha-256 with front end, command queue and round engine
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   operation, data_byte
// out_ch    out  digest_word, word_index, last_word
//
// an absorb item writes one byte; the 64th byte of a block starts a
// compression (load, 64 rounds, add) in the round engine. a finish item
// writes up to 72 padding bytes, one a cycle while the queue has room,
// with one or two compressions, then eight digest items, one per cycle when
// out_ch is ready. reset restores the initial hash values; no clearing pass.
module sha256_stream_hasher #(
	parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
	input logic        clk,
	input logic        arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	import sha_pkg::*;

	cmd_t fcmd, qcmd;
	logic fvalid, fready, qvalid, qready;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(fcmd), .cmd_valid(fvalid), .cmd_ready(fready)
	);

	sha_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_cmd(fcmd), .wr_valid(fvalid), .wr_ready(fready),
		.rd_cmd(qcmd), .rd_valid(qvalid), .rd_ready(qready)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.cmd(qcmd), .cmd_valid(qvalid), .cmd_ready(qready), .out_ch(out_ch)
	);
endmodule

[sv/sha_front.sv]
// ----------------------------------------------------------------------------
// sha256 front end
// takes items, tracks fill and length, expands finish into padding writes
// ----------------------------------------------------------------------------
module sha_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sha_stream_if.sink            in_ch,
	output sha_pkg::cmd_t         cmd,
	output logic                  cmd_valid,
	input  logic                  cmd_ready
);
	import sha_pkg::*;

	logic        pad_q;
	logic [5:0]  pos_q;
	logic        extra_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [63:0] plen_q;
	logic [2:0]  lsel;

	assign lsel = 3'(3'd7 - pos_q[2:0]);

	// padding sequence: byte 0x80 then zeros then length
	always_comb begin
		cmd = '0;
		cmd_valid = 1'b0;
		in_ch.ready = 1'b0;
		if (pad_q) begin
			cmd_valid = 1'b1;
			cmd.wr_en = 1'b1;
			cmd.wr_addr = pos_q;
			if (!extra_q && pos_q >= 6'd56)
				cmd.wr_data = plen_q[{lsel, 3'b000} +: 8];
			else
				cmd.wr_data = 8'h00;
			cmd.compress = (pos_q == 6'd63);
			cmd.emit = (pos_q == 6'd63) && !extra_q;
		end else begin
			in_ch.ready = cmd_ready;
			cmd_valid = in_ch.valid;
			cmd.wr_en = 1'b1;
			cmd.wr_addr = fill_q;
			if (in_ch.payload.operation == OP_FINISH) begin
				cmd.wr_data = 8'h80;
				cmd.compress = (fill_q == 6'd63);
				cmd.emit = 1'b0;
			end else begin
				cmd.wr_data = in_ch.payload.data_byte;
				cmd.compress = (fill_q == 6'd63);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= 1'b0;
			pos_q <= '0;
			extra_q <= 1'b0;
			fill_q <= '0;
			len_q <= '0;
			plen_q <= '0;
		end else if (pad_q) begin
			if (cmd_ready) begin
				pos_q <= 6'(pos_q + 6'd1);
				if (pos_q == 6'd63) begin
					if (extra_q)
						extra_q <= 1'b0;
					else
						pad_q <= 1'b0;
				end
			end
		end else if (in_ch.valid && cmd_ready) begin
			if (in_ch.payload.operation == OP_FINISH) begin
				pad_q <= 1'b1;
				pos_q <= 6'(fill_q + 6'd1);
				// 0x80 in the last byte closes the extra block itself
				extra_q <= (fill_q >= 6'd56) && (fill_q != 6'd63);
				plen_q <= len_q;
				fill_q <= '0;
				len_q <= '0;
			end else begin
				fill_q <= 6'(fill_q + 6'd1);
				len_q <= 64'(len_q + 64'd8);
			end
		end
	end
endmodule

[sv/sha_queue.sv]
// ----------------------------------------------------------------------------
// sha256 command queue
// small fifo between front and back end
// ----------------------------------------------------------------------------
module sha_queue #(
	parameter int unsigned Depth = sha_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::cmd_t wr_cmd,
	input  logic          wr_valid,
	output logic          wr_ready,
	output sha_pkg::cmd_t rd_cmd,
	output logic          rd_valid,
	input  logic          rd_ready
);
	import sha_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t            mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign wr_ready = (cnt_q != (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : AW'(wp_q + 1'b1);
			if (pop)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : AW'(rp_q + 1'b1);
			if (push && !pop)
				cnt_q <= (AW+1)'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= (AW+1)'(cnt_q - 1'b1);
		end
	end
endmodule

[sv/sha_core.sv]
// ----------------------------------------------------------------------------
// sha256 back end
// block words in the schedule window, one round per cycle, digest output
// ----------------------------------------------------------------------------
module sha_core (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	sha_stream_if.source  out_ch
);
	import sha_pkg::*;

	core_state_t state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  cnt_q;
	logic        emit_q;
	logic [2:0]  oidx_q;
	logic [31:0] s0, s1, wnew, t1, t2, wcur;
	logic        take;

	assign take = cmd_valid && cmd_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (take && cmd.compress) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 6'd63) state_d = ST_ADD;
			ST_ADD: state_d = emit_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (out_ch.ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_EMIT);
		out_ch.payload.digest_word = h_q[oidx_q];
		out_ch.payload.word_index = oidx_q;
		out_ch.payload.last_word = (oidx_q == 3'd7);
	end

	assign wcur = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = s1 + w_q[9] + s0 + w_q[0];
	assign t1 = hh_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + round_k(cnt_q) + wcur;
	assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// bytes land big-endian in the schedule window
	always_ff @(posedge clk) begin
		if (take && cmd.wr_en)
			w_q[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
		if (state_q == ST_LOAD) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			emit_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= init_h(3'(i));
		end else begin
			state_q <= state_d;
			if (take && cmd.compress)
				emit_q <= cmd.emit;
			if (state_q == ST_ROUND)
				cnt_q <= 6'(cnt_q + 6'd1);
			else
				cnt_q <= '0;
			if (state_q == ST_ADD) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
				h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
			end
			if (state_q == ST_EMIT && out_ch.ready) begin
				oidx_q <= 3'(oidx_q + 3'd1);
				if (oidx_q == 3'd7)
					for (int i = 0; i < 8; i++)
						h_q[i] <= init_h(3'(i));
			end
		end
	end
endmodule

[sv/sha_checker.sv]
// ----------------------------------------------------------------------------
// sha256 port checker
// checks on the digest item sequence seen at the top level
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"

module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  word_index,
	input logic        last_word,
	input logic [31:0] digest_word
);
	`SHA_ASSERT_IMP(a_last_idx, clk, arst_n, out_valid, last_word == (word_index == 3'd7))
	`SHA_ASSERT_NXT(a_idx_step, clk, arst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)
	`SHA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_index(out_ch.payload.word_index), .last_word(out_ch.payload.last_word),
	.digest_word(out_ch.payload.digest_word)
);
